>>> rtl/core/tbs_pkg.sv
// Shared constants and types for the triangle barycentric shader.
`default_nettype none
package tbs_pkg;
  localparam int CoordBits = 12;
  localparam int PixW      = 12;
  localparam int XyW       = 24;
  localparam int ChanW     = 8;
  localparam int DiffW     = CoordBits + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int SumW      = ProdW + 3;
  localparam int MagW      = ProdW;
  localparam int NumW      = MagW + ChanW + 2;
  localparam int RegIdxW   = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegV0Xy  = 3'd0,
    RegV1Xy  = 3'd1,
    RegV2Xy  = 3'd2,
    RegV0Rgb = 3'd3,
    RegV1Rgb = 3'd4,
    RegV2Rgb = 3'd5
  } reg_idx_e;

  // Coverage and edge magnitudes, already folded to a positive winding.
  typedef struct packed {
    logic                 cov;
    logic [MagW-1:0]      det;
    logic [2:0][MagW-1:0] e;
  } tbs_edge_t;

  // Per-channel numerators ready for division.
  typedef struct packed {
    logic                 cov;
    logic [MagW-1:0]      det;
    logic [2:0][NumW-1:0] num;
  } tbs_num_t;
endpackage
`default_nettype wire

>>> rtl/core/triangle_barycentric_shader.sv
// Top level: configuration registers, stall control and stream ports.
// Takes one pixel per clock unless a finished result waits at the output, and
// returns one coverage/colour result per pixel, in order: five stages form the
// edge functions and the coverage test, two form the weighted colour sums, and an
// eight-stage restoring divider (one quotient bit per stage) forms the channels.
// The whole pipeline holds while a finished result is not taken. The user must write
// vertex registers through cfg_we_i only while no pixel is in flight (unchecked).
`default_nettype none
module triangle_barycentric_shader import tbs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [RegIdxW-1:0] cfg_idx_i,
  input  wire logic [XyW-1:0]     cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [23:0]        s_axis_tdata,  // pixel_x, pixel_y
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [31:0]             m_axis_tdata   // covered, red, green, blue, zero pad
);
  logic [2:0][XyW-1:0]       xy_q, rgb_q;
  logic [2:0][CoordBits-1:0] x, y;
  logic                      en;
  logic                      edge_v, blend_v, div_v, div_cov;
  tbs_edge_t                 edge_s;
  tbs_num_t                  num_s;
  logic [2:0][ChanW-1:0]     chan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xy_q  <= '0;
      rgb_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegV0Xy:  xy_q[0]  <= cfg_wdata_i;
        RegV1Xy:  xy_q[1]  <= cfg_wdata_i;
        RegV2Xy:  xy_q[2]  <= cfg_wdata_i;
        RegV0Rgb: rgb_q[0] <= cfg_wdata_i;
        RegV1Rgb: rgb_q[1] <= cfg_wdata_i;
        RegV2Rgb: rgb_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x[i] = xy_q[i][CoordBits-1:0];
      y[i] = xy_q[i][2*CoordBits-1:CoordBits];
    end
  end

  // advance everything unless the output holds an untaken result
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  tbs_edge u_edge (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .px_i(s_axis_tdata[CoordBits-1:0]),
    .py_i(s_axis_tdata[PixW +: CoordBits]),
    .x_i(x), .y_i(y), .valid_o(edge_v), .edge_o(edge_s)
  );

  tbs_blend u_blend (
    .clk_i, .rst_ni, .en_i(en), .valid_i(edge_v), .edge_i(edge_s),
    .rgb_i(rgb_q), .valid_o(blend_v), .num_o(num_s)
  );

  tbs_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(blend_v), .num_i(num_s),
    .valid_o(div_v), .cov_o(div_cov), .chan_o(chan)
  );

  assign m_axis_tvalid = div_v;
  assign m_axis_tdata  = {7'd0, chan[2], chan[1], chan[0], div_cov};

  a_uncov_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[24:1] == '0)
    else $error("uncovered pixel with nonzero colour");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("pixel taken while output stalled");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
endmodule
`default_nettype wire

>>> rtl/core/tbs_edge.sv
// Edge function, determinant and coverage pipeline (five stages).
`default_nettype none
module tbs_edge import tbs_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [CoordBits-1:0]      px_i,
  input  wire logic [CoordBits-1:0]      py_i,
  input  wire logic [2:0][CoordBits-1:0] x_i,
  input  wire logic [2:0][CoordBits-1:0] y_i,
  output logic                           valid_o,
  output tbs_edge_t                      edge_o
);
  logic [4:0] v_q;

  // stage 1: coordinate differences
  logic signed [DiffW-1:0] dy12_q, dx21_q, dy20_q, dx02_q, dpx_q, dpy_q, dy02_q;
  // stage 2: products
  logic signed [ProdW-1:0] p_q [6];
  // stage 3: det, e0, e1
  logic signed [SumW-1:0]  det3_q, e0_3_q, e1_3_q;
  // stage 4: e2 and coverage
  logic signed [SumW-1:0]  det4_q, e0_4_q, e1_4_q, e2_4_q;
  logic                    cov4_q, neg4_q;
  logic signed [SumW-1:0]  e2_d;
  logic                    pos_d, neg_d, cov_d;
  tbs_edge_t               edge_d, edge_q;

  always_comb begin
    e2_d  = det3_q - e0_3_q - e1_3_q;
    neg_d = det3_q[SumW-1];
    pos_d = !det3_q[SumW-1] && (det3_q != '0);
    if (pos_d) begin
      cov_d = !e0_3_q[SumW-1] && !e1_3_q[SumW-1] && !e2_d[SumW-1];
    end else if (neg_d) begin
      cov_d = (e0_3_q[SumW-1] || e0_3_q == '0) && (e1_3_q[SumW-1] || e1_3_q == '0) &&
              (e2_d[SumW-1] || e2_d == '0);
    end else begin
      cov_d = 1'b0;
    end
  end

  always_comb begin
    edge_d.cov  = cov4_q;
    edge_d.det  = neg4_q ? MagW'(-det4_q) : MagW'(det4_q);
    edge_d.e[0] = neg4_q ? MagW'(-e0_4_q) : MagW'(e0_4_q);
    edge_d.e[1] = neg4_q ? MagW'(-e1_4_q) : MagW'(e1_4_q);
    edge_d.e[2] = neg4_q ? MagW'(-e2_4_q) : MagW'(e2_4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dy12_q <= {1'b0, y_i[1]} - {1'b0, y_i[2]};
      dx21_q <= {1'b0, x_i[2]} - {1'b0, x_i[1]};
      dy20_q <= {1'b0, y_i[2]} - {1'b0, y_i[0]};
      dx02_q <= {1'b0, x_i[0]} - {1'b0, x_i[2]};
      dy02_q <= {1'b0, y_i[0]} - {1'b0, y_i[2]};
      dpx_q  <= {1'b0, px_i} - {1'b0, x_i[2]};
      dpy_q  <= {1'b0, py_i} - {1'b0, y_i[2]};
      p_q[0] <= ProdW'(dy12_q) * ProdW'(dx02_q);
      p_q[1] <= ProdW'(dx21_q) * ProdW'(dy02_q);
      p_q[2] <= ProdW'(dy12_q) * ProdW'(dpx_q);
      p_q[3] <= ProdW'(dx21_q) * ProdW'(dpy_q);
      p_q[4] <= ProdW'(dy20_q) * ProdW'(dpx_q);
      p_q[5] <= ProdW'(dx02_q) * ProdW'(dpy_q);
      det3_q <= SumW'(p_q[0]) + SumW'(p_q[1]);
      e0_3_q <= SumW'(p_q[2]) + SumW'(p_q[3]);
      e1_3_q <= SumW'(p_q[4]) + SumW'(p_q[5]);
      det4_q <= det3_q;
      e0_4_q <= e0_3_q;
      e1_4_q <= e1_3_q;
      e2_4_q <= e2_d;
      cov4_q <= cov_d;
      neg4_q <= neg_d;
      edge_q <= edge_d;
    end
  end

  assign valid_o = v_q[4];
  assign edge_o  = edge_q;
endmodule
`default_nettype wire

>>> rtl/core/tbs_blend.sv
// Weighted colour sums: products then per-channel sums (two stages).
`default_nettype none
module tbs_blend import tbs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire tbs_edge_t           edge_i,
  input  wire logic [2:0][XyW-1:0] rgb_i,
  output logic                     valid_o,
  output tbs_num_t                 num_o
);
  localparam int PW = MagW + ChanW;

  logic [1:0]    v_q;
  logic [PW-1:0] p_q [3][3];
  logic          cov_q;
  logic [MagW-1:0] det_q;
  tbs_num_t      num_d, num_q;

  always_comb begin
    num_d.cov = cov_q;
    num_d.det = det_q;
    for (int ch = 0; ch < 3; ch++) begin
      num_d.num[ch] = NumW'(p_q[ch][0]) + NumW'(p_q[ch][1]) + NumW'(p_q[ch][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  // channel 0 is red (bits 23:16), 2 is blue (bits 7:0)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int vx = 0; vx < 3; vx++) begin
          p_q[ch][vx] <= PW'(edge_i.e[vx]) * PW'(rgb_i[vx][(2-ch)*ChanW +: ChanW]);
        end
      end
      cov_q <= edge_i.cov;
      det_q <= edge_i.det;
      num_q <= num_d;
    end
  end

  assign valid_o = v_q[1];
  assign num_o   = num_q;
endmodule
`default_nettype wire

>>> rtl/core/tbs_div.sv
// Restoring divider, one quotient bit per stage, three channels in lockstep.
`default_nettype none
module tbs_div import tbs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire tbs_num_t               num_i,
  output logic                        valid_o,
  output logic                        cov_o,
  output logic [2:0][ChanW-1:0]       chan_o
);
  logic [ChanW-1:0]            v_q;
  logic [ChanW-1:0]            cov_q;
  logic [MagW-1:0]             d_q  [ChanW];
  logic [2:0][NumW-1:0]        r_q  [ChanW];
  logic [2:0][ChanW-1:0]       qt_q [ChanW];
  logic [2:0]                  sat_q [ChanW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[ChanW-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < ChanW; s++) begin : g_stage
    localparam int Sh = ChanW - 1 - s;
    logic [MagW-1:0]       d_in;
    logic [2:0][NumW-1:0]  r_in;
    logic [2:0][ChanW-1:0] q_in;
    logic [2:0]            sat_in;
    logic                  cov_in;
    logic [2:0][NumW-1:0]  r_d;
    logic [2:0][ChanW-1:0] q_d;

    if (s == 0) begin : g_first
      assign d_in   = num_i.det;
      assign r_in   = num_i.num;
      assign q_in   = '0;
      assign cov_in = num_i.cov;
      // quotient would not fit in a channel: clamp
      for (genvar c = 0; c < 3; c++) begin : g_sat
        assign sat_in[c] = num_i.num[c] >= (NumW'(num_i.det) << ChanW);
      end
    end else begin : g_next
      assign d_in   = d_q[s-1];
      assign r_in   = r_q[s-1];
      assign q_in   = qt_q[s-1];
      assign sat_in = sat_q[s-1];
      assign cov_in = cov_q[s-1];
    end

    always_comb begin
      logic [NumW-1:0] dsh;
      logic            ge;
      for (int c = 0; c < 3; c++) begin
        dsh     = NumW'(d_in) << Sh;
        ge      = r_in[c] >= dsh;
        r_d[c]  = ge ? r_in[c] - dsh : r_in[c];
        q_d[c]  = q_in[c];
        q_d[c][Sh] = ge;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s]   <= d_in;
        r_q[s]   <= r_d;
        qt_q[s]  <= q_d;
        sat_q[s] <= sat_in;
        cov_q[s] <= cov_in;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!cov_q[ChanW-1]) begin
        chan_o[c] = '0;
      end else if (sat_q[ChanW-1][c]) begin
        chan_o[c] = '1;
      end else begin
        chan_o[c] = qt_q[ChanW-1][c];
      end
    end
  end

  assign valid_o = v_q[ChanW-1];
  assign cov_o   = cov_q[ChanW-1];

  a_rem_below_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ChanW-1] && cov_q[ChanW-1] && !sat_q[ChanW-1][0] |->
      r_q[ChanW-1][0] < NumW'(d_q[ChanW-1]))
    else $error("red remainder not below divisor");
endmodule
`default_nettype wire

>>> tb/tb_triangle_barycentric_shader.sv
// Self-checking testbench for the triangle barycentric shader stream block.
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_barycentric_shader;
  import tbs_pkg::*;

  typedef struct packed {
    logic       cov;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } shade_t;

  // directed row: pixel, optional known shade
  typedef struct {
    logic [11:0] px;
    logic [11:0] py;
    bit          known;
    shade_t      shade;
  } pix_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [XyW-1:0]     cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;  // pixel_x, pixel_y
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;       // covered, red, green, blue, zero pad

  triangle_barycentric_shader dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [23:0] vert_xy [3];
  logic [23:0] vert_rgb[3];
  shade_t      shade_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          stim_done = 0;

  function automatic longint chan_of(logic [23:0] rgb, int sh);
    return longint'((rgb >> sh) & 24'hFF);
  endfunction

  function automatic shade_t shade_pixel(logic [11:0] px, logic [11:0] py);
    longint x[3], y[3], det, e0, e1, e2, num, q;
    shade_t s;
    int sh[3];
    bit cov;
    sh = '{16, 8, 0};
    for (int i = 0; i < 3; i++) begin
      x[i] = longint'(vert_xy[i][11:0]);
      y[i] = longint'(vert_xy[i][23:12]);
    end
    det = (y[1]-y[2])*(x[0]-x[2]) + (x[2]-x[1])*(y[0]-y[2]);
    e0  = (y[1]-y[2])*(px-x[2]) + (x[2]-x[1])*(py-y[2]);
    e1  = (y[2]-y[0])*(px-x[2]) + (x[0]-x[2])*(py-y[2]);
    e2  = det - e0 - e1;
    if (det > 0) cov = e0 >= 0 && e1 >= 0 && e2 >= 0;
    else if (det < 0) cov = e0 <= 0 && e1 <= 0 && e2 <= 0;
    else cov = 0;
    s = '0;
    if (cov) begin
      s.cov = 1'b1;
      for (int c = 0; c < 3; c++) begin
        num = e0*chan_of(vert_rgb[0], sh[c]) + e1*chan_of(vert_rgb[1], sh[c])
            + e2*chan_of(vert_rgb[2], sh[c]);
        if (det < 0) begin
          num = -num;
          q = num / -det;
        end else begin
          q = num / det;
        end
        if (num < 0) q = 0;
        if (q > 255) q = 255;
        if (c == 0) s.r = q[7:0];
        else if (c == 1) s.g = q[7:0];
        else s.b = q[7:0];
      end
    end
    return s;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == RegV0Xy || idx == RegV1Xy || idx == RegV2Xy) vert_xy[idx] = val;
    else vert_rgb[idx - RegV0Rgb] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_triangle(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                              logic [23:0] ca, logic [23:0] cb, logic [23:0] cc);
    write_reg(RegV0Xy, a);
    write_reg(RegV1Xy, b);
    write_reg(RegV2Xy, c);
    write_reg(RegV0Rgb, ca);
    write_reg(RegV1Rgb, cb);
    write_reg(RegV2Rgb, cc);
  endtask

  // optionally hold off, then push one pixel request
  task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit known, shade_t ks);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {py, px};
    shade_q.push_back(known ? ks : shade_pixel(px, py));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [23:0] xy(int x, int y);
    return {y[11:0], x[11:0]};
  endfunction

  function automatic logic [11:0] near(int c);
    int v;
    v = c + $urandom_range(0, 80) - 40;
    return v < 0 ? 12'd0 : v > 4095 ? 12'd4095 : v[11:0];
  endfunction

  // receive side: random stall per result, compare against the oldest request
  initial begin : rx
    shade_t got, exp_s;
    int stall;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.cov = m_axis_tdata[0];
      got.r   = m_axis_tdata[8:1];
      got.g   = m_axis_tdata[16:9];
      got.b   = m_axis_tdata[24:17];
      if (shade_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_s = shade_q.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cov=%0d rgb=%h_%h_%h got cov=%0d rgb=%h_%h_%h",
                     exp_s.cov, exp_s.r, exp_s.g, exp_s.b, got.cov, got.r, got.g, got.b);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stim
    pix_row_t rows[$];
    int vx[3], vy[3];
    for (int i = 0; i < 3; i++) begin
      vert_xy[i] = '0;
      vert_rgb[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset the triangle is degenerate: nothing covered
    rows.push_back('{12'd0, 12'd0, 1, '0});
    rows.push_back('{12'hFFF, 12'hFFF, 1, '0});
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].shade);
    drain();

    // full-range triangle, white at every vertex: covered pixels are white
    set_triangle(xy(0, 0), xy(4095, 0), xy(0, 4095), 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    rows = {};
    rows.push_back('{12'd0, 12'd0, 1, '{1'b1, 8'hFF, 8'hFF, 8'hFF}});
    rows.push_back('{12'hFFF, 12'd0, 1, '{1'b1, 8'hFF, 8'hFF, 8'hFF}});
    rows.push_back('{12'd0, 12'hFFF, 1, '{1'b1, 8'hFF, 8'hFF, 8'hFF}});
    rows.push_back('{12'hFFF, 12'hFFF, 1, '0});
    rows.push_back('{12'd2047, 12'd2048, 1, '{1'b1, 8'hFF, 8'hFF, 8'hFF}});
    rows.push_back('{12'd2048, 12'd2048, 1, '0});
    rows.push_back('{12'd100, 12'd1000, 0, '0});
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].shade);
    drain();

    // reversed winding with distinct colors; the extreme corner vertex too
    set_triangle(xy(0, 0), xy(0, 4095), xy(4095, 4095), 24'hFF0000, 24'h00FF00, 24'h0000FF);
    rows = {};
    rows.push_back('{12'd0, 12'd0, 1, '{1'b1, 8'hFF, 8'h00, 8'h00}});
    rows.push_back('{12'd0, 12'hFFF, 1, '{1'b1, 8'h00, 8'hFF, 8'h00}});
    rows.push_back('{12'hFFF, 12'hFFF, 1, '{1'b1, 8'h00, 8'h00, 8'hFF}});
    rows.push_back('{12'hFFF, 12'd0, 1, '0});
    rows.push_back('{12'd1000, 12'd3000, 0, '0});
    rows.push_back('{12'd2048, 12'd2048, 0, '0});
    rows.push_back('{12'd1365, 12'd2730, 0, '0});
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].shade);
    drain();

    // collinear vertices: degenerate, never covered
    set_triangle(xy(10, 10), xy(20, 20), xy(30, 30), 24'h123456, 24'h789ABC, 24'hDEF012);
    rows = {};
    rows.push_back('{12'd20, 12'd20, 1, '0});
    rows.push_back('{12'd10, 12'd10, 1, '0});
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].shade);
    drain();

    // random triangles, mostly small, pixels mostly near them
    for (int t = 0; t < 26; t++) begin
      for (int i = 0; i < 3; i++) begin
        if (t % 5 == 0) begin
          vx[i] = $urandom_range(0, 4095);
          vy[i] = $urandom_range(0, 4095);
        end else begin
          vx[i] = (i == 0) ? $urandom_range(0, 4095)
                           : near(vx[0]) + $urandom_range(0, 1);
          vy[i] = (i == 0) ? $urandom_range(0, 4095) : near(vy[0]);
          if (vx[i] > 4095) vx[i] = 4095;
        end
      end
      set_triangle(xy(vx[0], vy[0]), xy(vx[1], vy[1]), xy(vx[2], vy[2]),
                   $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                   $urandom_range(0, 24'hFFFFFF));
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(0, 9) < 8)
          send_pixel(near((vx[0] + vx[1] + vx[2]) / 3), near((vy[0] + vy[1] + vy[2]) / 3),
                     0, '0);
        else
          send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), 0, '0);
      end
      drain();
    end

    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
